// File: design/zpc_pkg.sv
// Package for the ZMP preview controller: state, operation and register codes.
// No dependencies; the files that use it refer to it by scoped names.
package zpc_pkg;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_TAPS  = 7'b0000010,
    ST_DRAIN = 7'b0000100,
    ST_ISSUE = 7'b0001000,
    ST_WAIT  = 7'b0010000,
    ST_TAKE  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  // scalar multiply sequence of one axis, in issue order
  typedef enum logic [3:0] {
    OP_ERR = 4'd0,
    OP_SP  = 4'd1,
    OP_SV  = 4'd2,
    OP_SA  = 4'd3,
    OP_PV  = 4'd4,
    OP_PA  = 4'd5,
    OP_PU  = 4'd6,
    OP_VA  = 4'd7,
    OP_VU  = 4'd8,
    OP_AU  = 4'd9,
    OP_ZMP = 4'd10
  } op_e;

  typedef enum logic [2:0] {
    CFG_DT       = 3'd0,
    CFG_DT_SQ    = 3'd1,
    CFG_DT_CUBE  = 3'd2,
    CFG_RATIO    = 3'd3,
    CFG_ERR_GAIN = 3'd4,
    CFG_GAIN_POS = 3'd5,
    CFG_GAIN_VEL = 3'd6,
    CFG_GAIN_ACC = 3'd7
  } cfg_e;

  localparam int unsigned NumCfg = 8;
  localparam logic [31:0] CfgReset [NumCfg] = '{
    32'd327, 32'd1, 32'd0, 32'hFFFF_EB1F, 32'd0, 32'd0, 32'd0, 32'd0
  };

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

// File: design/zpc_in_if.sv
// Input channel of the ZMP preview controller: gain loads and reference pushes.
// Standalone interface, no dependencies.
interface zpc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  tap_index;
  logic [31:0] gain_value;
  logic [31:0] ref_x;
  logic [31:0] ref_y;

  modport source (output valid, func, tap_index, gain_value, ref_x, ref_y, input ready);
  modport sink   (input valid, func, tap_index, gain_value, ref_x, ref_y, output ready);
endinterface

// File: design/zpc_out_if.sv
// Result channel of the ZMP preview controller: next CoM state, ZMP and jerk.
// Standalone interface, no dependencies.
interface zpc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] com_pos_x;
  logic [31:0] com_pos_y;
  logic [31:0] com_vel_x;
  logic [31:0] com_vel_y;
  logic [31:0] com_acc_x;
  logic [31:0] com_acc_y;
  logic [31:0] zmp_x;
  logic [31:0] zmp_y;
  logic [31:0] jerk_x;
  logic [31:0] jerk_y;

  modport source (output valid, com_pos_x, com_pos_y, com_vel_x, com_vel_y, com_acc_x,
                  com_acc_y, zmp_x, zmp_y, jerk_x, jerk_y, input ready);
  modport sink   (input valid, com_pos_x, com_pos_y, com_vel_x, com_vel_y, com_acc_x,
                  com_acc_y, zmp_x, zmp_y, jerk_x, jerk_y, output ready);
endinterface

// File: design/zpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module zpc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: design/zpc_mul.sv
// Shared Q16.16 multiplier: registered operands, registered 64-bit product.
// The result is taken from the product register, which follows the operand registers. Depends on zpc_pkg.
module zpc_mul (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [31:0]          a_i,
  input  logic [31:0]          b_i,
  output logic [31:0]          res_o,
  output zpc_pkg::mul_stat_t   stat_o
);
  logic [31:0]        a_q, b_q;
  logic signed [63:0] prod_q;
  logic               v1_q, v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_i;
    b_q    <= b_i;
    prod_q <= $signed(a_q) * $signed(b_q);
  end

  // floor shift by 16, keep low word
  assign res_o       = prod_q[47:16];
  assign stat_o.busy = v1_q | v2_q;
  assign stat_o.done = v2_q;
endmodule

// File: design/zmp_preview_controller.sv
// Top level of the cart-table ZMP preview controller (Q16.16, both axes).
// Depends on zpc_pkg, zpc_in_if, zpc_out_if, zpc_ram and zpc_mul.
//
//  channel  | dir | handshake     | payload
//  in_i     | in  | valid / ready | func, tap_index, gain_value, ref_x, ref_y
//  out_o    | out | valid / ready | com pos/vel/acc x,y, zmp x,y, jerk x,y
//  cfg      | in  | cfg_we_i      | cfg_idx_i, cfg_data_i
//
// Gain loads and pushes that do not step leave input ready high. A step runs per axis
// one tap pass through the shared multiplier and 11 scalar multiplies, then the
// result waits in the output registers until taken; input ready is low meanwhile.
// Reset clears state, window fill and axis registers and sets the config defaults;
// gain and window memory are not cleared.
module zmp_preview_controller #(
  parameter int unsigned PREVIEW_TAPS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  zpc_in_if.sink      in_i,
  zpc_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  localparam int unsigned PW = $clog2(PREVIEW_TAPS);
  localparam int unsigned FW = $clog2(PREVIEW_TAPS + 1);

  zpc_pkg::state_e state_q, state_d;
  zpc_pkg::op_e    op_q;
  logic            ax_q;
  logic [PW-1:0]   k_q, ptr_q, win_raddr, gain_raddr, gain_waddr;
  logic [PW:0]     rsum;
  logic [FW-1:0]   fill_q;
  logic [31:0]     cfg_q [zpc_pkg::NumCfg];
  logic [31:0]     acc_q, w0_q, prevw_q;
  logic            rd_v_q, rd_first_q;
  logic [31:0]     pos_q [2], vel_q [2], accs_q [2], zmp_q [2], jerk_q [2];
  logic [31:0]     ppos_q [2], pvel_q [2], pacc_q [2];

  logic            in_acc, is_push, step_go, win_we, gain_we;
  logic [63:0]     win_rd;
  logic [31:0]     gain_rd, win_ax, mul_a, mul_b, mul_res, diff_acc;
  logic            mul_v;
  zpc_pkg::mul_stat_t mul_stat;

  assign in_i.ready = (state_q == zpc_pkg::ST_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;
  assign is_push    = in_acc & in_i.func;
  assign step_go    = is_push & (fill_q >= FW'(PREVIEW_TAPS - 1));
  assign win_we     = is_push;
  assign gain_we    = in_acc & ~in_i.func & (32'(in_i.tap_index) < 32'(PREVIEW_TAPS));
  assign gain_waddr = PW'(in_i.tap_index);
  assign gain_raddr = k_q - PW'(1);

  always_comb begin
    rsum = (PW+1)'(ptr_q) + (PW+1)'(k_q);
    if (rsum >= (PW+1)'(PREVIEW_TAPS)) begin
      rsum = rsum - (PW+1)'(PREVIEW_TAPS);
    end
    win_raddr = rsum[PW-1:0];
  end

  zpc_ram #(.Width(64), .Depth(PREVIEW_TAPS)) u_win (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (ptr_q),
    .wdata_i ({in_i.ref_y, in_i.ref_x}),
    .raddr_i (win_raddr),
    .rdata_o (win_rd)
  );

  zpc_ram #(.Width(32), .Depth(PREVIEW_TAPS)) u_gain (
    .clk_i   (clk_i),
    .we_i    (gain_we),
    .waddr_i (gain_waddr),
    .wdata_i (in_i.gain_value),
    .raddr_i (gain_raddr),
    .rdata_o (gain_rd)
  );

  assign win_ax = ax_q ? win_rd[63:32] : win_rd[31:0];

  // operand select for the shared multiplier
  always_comb begin
    mul_a = gain_rd;
    mul_b = win_ax - prevw_q;
    mul_v = 1'b0;
    if (rd_v_q) begin
      mul_v = ~rd_first_q;
    end else if (state_q == zpc_pkg::ST_ISSUE) begin
      mul_v = 1'b1;
      unique case (op_q)
        zpc_pkg::OP_ERR: begin
          mul_a = cfg_q[zpc_pkg::CFG_ERR_GAIN];
          mul_b = zmp_q[ax_q] - w0_q;
        end
        zpc_pkg::OP_SP: begin
          mul_a = cfg_q[zpc_pkg::CFG_GAIN_POS];
          mul_b = pos_q[ax_q] - ppos_q[ax_q];
        end
        zpc_pkg::OP_SV: begin
          mul_a = cfg_q[zpc_pkg::CFG_GAIN_VEL];
          mul_b = vel_q[ax_q] - pvel_q[ax_q];
        end
        zpc_pkg::OP_SA: begin
          mul_a = cfg_q[zpc_pkg::CFG_GAIN_ACC];
          mul_b = accs_q[ax_q] - pacc_q[ax_q];
        end
        zpc_pkg::OP_PV: begin
          mul_a = cfg_q[zpc_pkg::CFG_DT];
          mul_b = vel_q[ax_q];
        end
        zpc_pkg::OP_PA: begin
          mul_a = cfg_q[zpc_pkg::CFG_DT_SQ];
          mul_b = accs_q[ax_q];
        end
        zpc_pkg::OP_PU: begin
          mul_a = cfg_q[zpc_pkg::CFG_DT_CUBE];
          mul_b = jerk_q[ax_q];
        end
        zpc_pkg::OP_VA: begin
          mul_a = cfg_q[zpc_pkg::CFG_DT];
          mul_b = accs_q[ax_q];
        end
        zpc_pkg::OP_VU: begin
          mul_a = cfg_q[zpc_pkg::CFG_DT_SQ];
          mul_b = jerk_q[ax_q];
        end
        zpc_pkg::OP_AU: begin
          mul_a = cfg_q[zpc_pkg::CFG_DT];
          mul_b = jerk_q[ax_q];
        end
        zpc_pkg::OP_ZMP: begin
          mul_a = cfg_q[zpc_pkg::CFG_RATIO];
          mul_b = accs_q[ax_q];
        end
        default: begin
          mul_a = cfg_q[zpc_pkg::CFG_DT];
          mul_b = accs_q[ax_q];
        end
      endcase
    end
  end

  zpc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_v),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .res_o   (mul_res),
    .stat_o  (mul_stat)
  );

  assign diff_acc = acc_q - mul_res;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      zpc_pkg::ST_IDLE:  if (step_go) state_d = zpc_pkg::ST_TAPS;
      zpc_pkg::ST_TAPS:  if (k_q == PW'(PREVIEW_TAPS - 1)) state_d = zpc_pkg::ST_DRAIN;
      zpc_pkg::ST_DRAIN: if (!rd_v_q && !mul_stat.busy) state_d = zpc_pkg::ST_ISSUE;
      zpc_pkg::ST_ISSUE: state_d = zpc_pkg::ST_WAIT;
      zpc_pkg::ST_WAIT:  state_d = zpc_pkg::ST_TAKE;
      zpc_pkg::ST_TAKE: begin
        if (op_q != zpc_pkg::OP_ZMP) state_d = zpc_pkg::ST_ISSUE;
        else if (!ax_q)              state_d = zpc_pkg::ST_TAPS;
        else                         state_d = zpc_pkg::ST_OUT;
      end
      zpc_pkg::ST_OUT:   if (out_o.ready) state_d = zpc_pkg::ST_IDLE;
      default:           state_d = zpc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= zpc_pkg::ST_IDLE;
      op_q       <= zpc_pkg::OP_ERR;
      ax_q       <= 1'b0;
      k_q        <= '0;
      ptr_q      <= '0;
      fill_q     <= '0;
      acc_q      <= '0;
      rd_v_q     <= 1'b0;
      rd_first_q <= 1'b0;
      for (int i = 0; i < zpc_pkg::NumCfg; i++) cfg_q[i] <= zpc_pkg::CfgReset[i];
      for (int a = 0; a < 2; a++) begin
        pos_q[a]  <= '0;
        vel_q[a]  <= '0;
        accs_q[a] <= '0;
        zmp_q[a]  <= '0;
        jerk_q[a] <= '0;
        ppos_q[a] <= '0;
        pvel_q[a] <= '0;
        pacc_q[a] <= '0;
      end
    end else begin
      state_q    <= state_d;
      rd_v_q     <= (state_q == zpc_pkg::ST_TAPS);
      rd_first_q <= (state_q == zpc_pkg::ST_TAPS) && (k_q == '0);

      if (cfg_we_i) cfg_q[cfg_idx_i] <= cfg_data_i;

      if (is_push) begin
        ptr_q <= (ptr_q == PW'(PREVIEW_TAPS - 1)) ? '0 : ptr_q + PW'(1);
        if (fill_q != FW'(PREVIEW_TAPS)) fill_q <= fill_q + FW'(1);
      end

      if (step_go) begin
        ax_q  <= 1'b0;
        k_q   <= '0;
        acc_q <= '0;
      end

      if (state_q == zpc_pkg::ST_TAPS) k_q <= k_q + PW'(1);

      // accumulate preview products
      if ((state_q == zpc_pkg::ST_TAPS || state_q == zpc_pkg::ST_DRAIN) && mul_stat.done) begin
        acc_q <= acc_q + mul_res;
      end
      if (state_q == zpc_pkg::ST_DRAIN) op_q <= zpc_pkg::OP_ERR;

      if (state_q == zpc_pkg::ST_TAKE) begin
        op_q <= zpc_pkg::op_e'(4'(op_q) + 4'd1);
        unique case (op_q)
          zpc_pkg::OP_ERR, zpc_pkg::OP_SP, zpc_pkg::OP_SV: acc_q <= diff_acc;
          zpc_pkg::OP_SA: begin
            jerk_q[ax_q] <= jerk_q[ax_q] + diff_acc;
            ppos_q[ax_q] <= pos_q[ax_q];
            pvel_q[ax_q] <= vel_q[ax_q];
            pacc_q[ax_q] <= accs_q[ax_q];
          end
          zpc_pkg::OP_PV, zpc_pkg::OP_PA, zpc_pkg::OP_PU: pos_q[ax_q] <= pos_q[ax_q] + mul_res;
          zpc_pkg::OP_VA, zpc_pkg::OP_VU: vel_q[ax_q] <= vel_q[ax_q] + mul_res;
          zpc_pkg::OP_AU: accs_q[ax_q] <= accs_q[ax_q] + mul_res;
          zpc_pkg::OP_ZMP: begin
            zmp_q[ax_q] <= pos_q[ax_q] + mul_res;
            // advance to the y axis pass
            if (!ax_q) begin
              ax_q  <= 1'b1;
              k_q   <= '0;
              acc_q <= '0;
            end
          end
          default: acc_q <= diff_acc;
        endcase
      end
    end
  end

  // capture oldest sample and hold previous sample for differences
  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      prevw_q <= win_ax;
      if (rd_first_q) w0_q <= win_ax;
    end
  end

  assign out_o.valid     = (state_q == zpc_pkg::ST_OUT);
  assign out_o.com_pos_x = pos_q[0];
  assign out_o.com_pos_y = pos_q[1];
  assign out_o.com_vel_x = vel_q[0];
  assign out_o.com_vel_y = vel_q[1];
  assign out_o.com_acc_x = accs_q[0];
  assign out_o.com_acc_y = accs_q[1];
  assign out_o.zmp_x     = zmp_q[0];
  assign out_o.zmp_y     = zmp_q[1];
  assign out_o.jerk_x    = jerk_q[0];
  assign out_o.jerk_y    = jerk_q[1];
endmodule

// File: design/zpc_chk.sv
// Port-level checker for the ZMP preview controller, bound to the top level.
// Depends only on the top level's ports.
module zpc_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_func_i,
  input logic out_valid_i,
  input logic out_ready_i
);
  // no new input while a result is held
  a_busy_when_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("input ready while result pending");

  // a gain load never produces a result and returns ready at once
  a_load_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && !in_func_i) |=> (in_ready_i && !out_valid_i))
    else $error("gain load produced result or stall");

  // result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i) else $error("result dropped");

  // one result per step
  a_out_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i) |=> (!out_valid_i && in_ready_i))
    else $error("result repeated");
endmodule

bind zmp_preview_controller zpc_chk u_zpc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_func_i   (in_i.func),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready)
);
